/* hw/rtl/pulse_sensor_heart_rate_tracker_macros.svh */
// ----------------------------------------------------------------------------
// pulse sensor heart rate tracker assertion macros
// shared property wrappers, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef PULSE_SENSOR_HEART_RATE_TRACKER_MACROS_SVH
`define PULSE_SENSOR_HEART_RATE_TRACKER_MACROS_SVH

// same-cycle implication
`define PSHR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSHR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pshr_pkg.sv */
// ----------------------------------------------------------------------------
// pshr_pkg
// types, sizes and codes shared by the heart rate tracker modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pshr_pkg;

  // periods held in the beat history ring
  localparam int WINDOW  = 16;
  localparam int SLOT_W  = $clog2(WINDOW);
  localparam int SEEN_W  = $clog2(WINDOW + 1);
  localparam int BEATS_W = 8;
  localparam int TOTAL_W = BEATS_W + SLOT_W;
  localparam int PPM_W   = 8;
  localparam int PROD_W  = TOTAL_W + PPM_W;
  localparam int STEP_W  = $clog2(PROD_W);
  localparam int BPM_W   = 16;
  localparam int LEN_W   = 16;
  localparam int MINP_W  = 5;
  localparam int TIME_W  = 32;
  localparam int LEVEL_W = 8;

  localparam logic [BEATS_W-1:0] BEATS_MAX    = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_PULSING = 8'h00;

  // reset values of the configuration registers
  localparam logic [LEN_W-1:0]  PERIOD_LENGTH_RESET = 16'd500;
  localparam logic [MINP_W-1:0] MIN_PERIODS_RESET   = 5'd8;
  localparam logic [PPM_W-1:0]  PPM_RESET           = 8'd120;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIODS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PPM           = 2'd2;
  localparam int CFG_DATA_W = LEN_W;

  // input item modes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [LEVEL_W-1:0] sensor_level;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic             pulsing;
    logic             beat;
    logic             rate_ready;
    logic [BPM_W-1:0] beats_per_minute;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  period_length_ms;
    logic [MINP_W-1:0] min_periods;
    logic [PPM_W-1:0]  periods_per_minute;
  } cfg_t;

  // work handed from the front end to the rate unit
  typedef struct packed {
    logic               pulsing;
    logic               beat;
    logic               rate_ready;
    logic [TOTAL_W-1:0] total;
    logic [SEEN_W-1:0]  seen;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

/* hw/rtl/pshr_front.sv */
// ----------------------------------------------------------------------------
// pshr_front
// takes samples and clear commands, tracks beats, periods and the history ring
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pshr_front (
  input  logic              clk,
  input  logic              rst,
  input  pshr_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  pshr_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              push_valid,
  output pshr_pkg::job_t     push_job
);
  import pshr_pkg::*;

  logic               pulse_level;
  logic               period_started;
  logic [TIME_W-1:0]  period_begin_ms;
  logic [BEATS_W-1:0] beats;
  logic [SEEN_W-1:0]  seen;
  logic [SLOT_W-1:0]  slot;
  logic [TOTAL_W-1:0] total;
  logic [BEATS_W-1:0] hist [WINDOW];
  logic [WINDOW-1:0]  hist_valid;

  logic               pulse_level_next;
  logic [TIME_W-1:0]  period_begin_ms_next;
  logic [BEATS_W-1:0] beats_next;
  logic [SEEN_W-1:0]  seen_next;
  logic [SLOT_W-1:0]  slot_next;
  logic [TOTAL_W-1:0] total_next;

  logic               accept;
  logic               sample_pulsing;
  logic               beat;
  logic [BEATS_W-1:0] beats_inc;
  logic [TIME_W-1:0]  begin_eff;
  logic [TIME_W-1:0]  elapsed;
  logic               close;
  logic [BEATS_W-1:0] old_beats;
  logic               ready;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    sample_pulsing = (in_item.sensor_level == LEVEL_PULSING);
    beat        = pulse_level && !sample_pulsing;
    beats_inc   = (beat && beats != BEATS_MAX) ? beats + 1'b1 : beats;
    begin_eff   = period_started ? period_begin_ms : in_item.now_ms;
    elapsed     = in_item.now_ms - begin_eff;
    close       = elapsed >= TIME_W'(cfg.period_length_ms);
    old_beats   = hist_valid[slot] ? hist[slot] : '0;

    pulse_level_next     = sample_pulsing;
    period_begin_ms_next = close ? in_item.now_ms : begin_eff;
    beats_next           = close ? '0 : beats_inc;
    seen_next            = seen;
    slot_next            = slot;
    total_next           = total;
    if (close) begin
      total_next = total - TOTAL_W'(old_beats) + TOTAL_W'(beats_inc);
      slot_next  = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
      if (seen != SEEN_W'(WINDOW)) begin
        seen_next = seen + 1'b1;
      end
    end

    ready = (seen_next != '0) && (32'(seen_next) >= 32'(cfg.min_periods));

    push_valid = accept;
    if (in_item.mode == MODE_CLEAR) begin
      push_job = '0;
    end else begin
      push_job.pulsing    = pulse_level_next;
      push_job.beat       = beat;
      push_job.rate_ready = ready;
      push_job.total      = total_next;
      push_job.seen       = seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_level     <= 1'b0;
      period_started  <= 1'b0;
      period_begin_ms <= '0;
      beats           <= '0;
      seen            <= '0;
      slot            <= '0;
      total           <= '0;
      hist_valid      <= '0;
    end else if (accept) begin
      if (in_item.mode == MODE_CLEAR) begin
        pulse_level     <= 1'b0;
        period_started  <= 1'b0;
        period_begin_ms <= '0;
        beats           <= '0;
        seen            <= '0;
        slot            <= '0;
        total           <= '0;
        hist_valid      <= '0;
      end else begin
        pulse_level     <= pulse_level_next;
        period_started  <= 1'b1;
        period_begin_ms <= period_begin_ms_next;
        beats           <= beats_next;
        seen            <= seen_next;
        slot            <= slot_next;
        total           <= total_next;
        if (close) begin
          hist_valid[slot] <= 1'b1;
        end
      end
    end
  end

  // ring storage, no reset: entries read through their valid bits
  always_ff @(posedge clk) begin
    if (accept && in_item.mode == MODE_SAMPLE && close) begin
      hist[slot] <= beats_inc;
    end
  end

endmodule

/* hw/rtl/pshr_queue.sv */
// ----------------------------------------------------------------------------
// pshr_queue
// two-entry queue of jobs between the front end and the rate unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pshr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  pshr_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output pshr_pkg::job_t pop_job
);
  import pshr_pkg::*;

  job_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_job   = entry[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_job;
    end
  end

endmodule

/* hw/rtl/pshr_back.sv */
// ----------------------------------------------------------------------------
// pshr_back
// rate unit: scale the history sum, divide serially by the period count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pulse_sensor_heart_rate_tracker_macros.svh"

module pshr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [pshr_pkg::PPM_W-1:0]  periods_per_minute,
  input  logic                        pop_valid,
  input  pshr_pkg::job_t              pop_job,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pshr_pkg::out_item_t         out_item
);
  import pshr_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  job_t              job;
  logic [PROD_W-1:0] quo;
  logic [SEEN_W-1:0] rem;
  logic [STEP_W-1:0] step;
  logic [SEEN_W:0]   trial;
  logic              fits;

  // one quotient bit per cycle, dividend shifts out of quo as bits shift in
  assign trial = {rem, quo[PROD_W-1]};
  assign fits  = trial >= {1'b0, job.seen};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (pop_valid) begin
          pop        = 1'b1;
          state_next = BK_MUL;
        end
      end
      BK_MUL: state_next = BK_DIV;
      BK_DIV: begin
        if (step == STEP_W'(PROD_W - 1)) begin
          state_next = BK_OUT;
        end
      end
      BK_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (pop_valid) begin
          job <= pop_job;
        end
      end
      BK_MUL: begin
        quo  <= PROD_W'(job.total) * PROD_W'(periods_per_minute);
        rem  <= '0;
        step <= '0;
      end
      BK_DIV: begin
        quo  <= {quo[PROD_W-2:0], fits};
        rem  <= fits ? SEEN_W'(trial - {1'b0, job.seen}) : SEEN_W'(trial);
        step <= step + 1'b1;
      end
      default: begin
        quo <= quo;
      end
    endcase
  end

  always_comb begin
    out_item.pulsing          = job.pulsing;
    out_item.beat             = job.beat;
    out_item.rate_ready       = job.rate_ready;
    out_item.beats_per_minute = job.rate_ready ? BPM_W'(quo) : '0;
  end

  `PSHR_ASSERT_NOW(a_no_rate_when_not_ready, out_valid && !out_item.rate_ready,
    out_item.beats_per_minute == '0, "rate shown before enough periods")
  `PSHR_ASSERT_NOW(a_step_in_range, state == BK_DIV,
    32'(step) < PROD_W, "divider step count overran")
  `PSHR_ASSERT_NEXT(a_mul_then_div, state == BK_MUL,
    state == BK_DIV && step == '0, "divider did not start after scaling")
  `PSHR_ASSERT_NOW(a_ready_has_periods, out_valid && out_item.rate_ready,
    job.seen != '0, "rate ready with no period gathered")

endmodule

/* hw/rtl/pulse_sensor_heart_rate_tracker.sv */
// item path: queue entry, then the rate unit's idle, scale, divide and output states
// the rate unit takes no new item until it is idle again, after its serial divider (one
//   quotient bit per cycle over the 20-bit scaled sum) and its scale and output steps
// the front end takes up to two items ahead of the rate unit through its queue
// reset: synchronous, clears all tracking state and the ring valid bits at once,
//   loads the register defaults; no clearing pass
// ----------------------------------------------------------------------------
// pulse_sensor_heart_rate_tracker
// beat detection and averaged heart rate from timestamped pulse sensor samples
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pulse_sensor_heart_rate_tracker (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes
  input  logic                              cfg_write,
  input  logic [pshr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pshr_pkg::CFG_DATA_W-1:0]   cfg_data,
  // sample input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pshr_pkg::in_item_t                in_item,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output pshr_pkg::out_item_t               out_item
);
  import pshr_pkg::*;

  cfg_t cfg;

  // front end to queue
  logic push_valid;
  job_t push_job;
  logic q_full;

  // queue to rate unit
  logic pop;
  logic pop_valid;
  job_t pop_job;

  // configuration registers, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_length_ms   <= PERIOD_LENGTH_RESET;
      cfg.min_periods        <= MIN_PERIODS_RESET;
      cfg.periods_per_minute <= PPM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PERIOD_LENGTH: cfg.period_length_ms   <= LEN_W'(cfg_data);
        CFG_MIN_PERIODS:   cfg.min_periods        <= MINP_W'(cfg_data);
        CFG_PPM:           cfg.periods_per_minute <= PPM_W'(cfg_data);
        default:           cfg <= cfg;
      endcase
    end
  end

  // front end: edge detect, period timing, history ring and running sum;
  // every transfer pushes one job, so the front stalls only on a full queue
  pshr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_job   (push_job)
  );

  // short decoupling queue so sampling and rate work stall separately
  pshr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job)
  );

  // rate unit: sum times periods per minute, divided by periods seen;
  // holds its result registered until the output transfer
  pshr_back u_back (
    .clk                (clk),
    .rst                (rst),
    .periods_per_minute (cfg.periods_per_minute),
    .pop_valid          (pop_valid),
    .pop_job            (pop_job),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_item           (out_item)
  );

endmodule
